[rtl/btlv_pkg.sv]
// ----------------------------------------------------------------------------
// btlv_pkg
// Types and constants shared by the BER-TLV stream parser modules.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int LEN_W = 24;

  // Phase of the parser, also the byte role code on the result channel
  typedef enum logic [2:0] {
    PH_TAG1 = 3'd0,
    PH_TAG2 = 3'd1,
    PH_LEN  = 3'd2,
    PH_LEXT = 3'd3,
    PH_VAL  = 3'd4
  } phase_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LEN_FORM = 2'd1;
  localparam logic [1:0] ERR_TOO_DEEP = 2'd2;
  localparam logic [1:0] ERR_OVERRUN  = 2'd3;

  localparam logic [7:0] TAG_MULTI_MASK  = 8'h1F;
  localparam logic [7:0] CONSTRUCTED_BIT = 8'h20;

  localparam logic [2:0] DEPTH_LIMIT_RST = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } btlv_in_t;

  typedef struct packed {
    logic [2:0]       byte_role;
    logic [15:0]      tag_number;
    logic [1:0]       tag_class;
    logic             is_constructed;
    logic [2:0]       nesting_depth;
    logic [LEN_W-1:0] value_length;
    logic             header_complete;
    logic [2:0]       levels_closed;
    logic [1:0]       error_code;
    logic             last_result;
  } btlv_out_t;

  // Control broadcast from the header decoder to every level cell
  typedef struct packed {
    logic             step;
    logic             flush;
    logic             push;
    logic [LEN_W-1:0] room;
  } btlv_cell_ctl_t;

endpackage

[rtl/ber_tlv_stream_parser.sv]
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser
// Labels each byte of a BER-TLV stream and tracks template nesting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_item carries one stream byte and
//   an end-of-message flag per item. The result channel out_valid /
//   out_stall / out_item returns one item per input byte with its role, the
//   tag, the decoded length, the nesting depth, closed levels and the sticky
//   error code.
//   Throughput is one byte per cycle while the receiver does not stall. A
//   byte accepted at an edge shows its result in the output register after
//   that edge. The per-byte step (header decode plus one countdown in every
//   open level cell of the chain) is combinational.
//   When the receiver stalls, the output register holds its item and
//   in_stall rises until that item is taken.
//   cfg_wr_en / cfg_wr_data write depth_limit; write it only while idle.
//   After reset the parser expects a first tag byte, no level is open, the
//   error is clear and depth_limit is 4. The byte flagged end_of_message
//   returns all parsing state to that idle state after its result.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser #(
  parameter int MAX_LEVELS   = 4,
  parameter int LENGTH_BYTES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  btlv_pkg::btlv_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output btlv_pkg::btlv_out_t out_item,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int LB_W  = $clog2(LENGTH_BYTES + 1);
  localparam int LW    = btlv_pkg::LEN_W;

  btlv_pkg::phase_t    phase_r, phase_nxt;
  logic [15:0]         tag_r, tag_nxt;
  logic                cons_r, cons_nxt;
  logic [LW-1:0]       acc_r, acc_nxt;
  logic [LB_W-1:0]     lb_left_r, lb_nxt, lb_dec;
  logic [LW-1:0]       vbl_r, vbl_nxt, vbl_dec;
  logic [CNT_W-1:0]    open_levels_r, open_nxt;
  logic [1:0]          err_r, err_nxt;
  logic [2:0]          depth_limit_r;
  logic                out_valid_r;
  btlv_pkg::btlv_out_t out_item_r, out_item_nxt;

  logic                in_acc;
  logic [7:0]          b;
  logic                eom;
  logic                long_ok;
  logic                hc;
  logic                bad;
  logic [LW-1:0]       vlen;
  logic [LW-1:0]       parent;
  logic [LW-1:0]       room;
  logic                has_parent;
  logic                overrun;
  logic                room_ok;
  logic                elem_ok;
  logic                push;
  logic                too_deep;
  logic                prim_start;
  logic [CNT_W-1:0]    closed_cnt;
  logic                close_err;

  logic [MAX_LEVELS-1:0] open_v;
  logic [MAX_LEVELS-1:0] closed_v;
  logic [MAX_LEVELS-1:0] top_v;
  logic [LW-1:0]         left_v [MAX_LEVELS];
  btlv_pkg::btlv_cell_ctl_t cell_ctl;

  assign b        = in_item.data_byte;
  assign eom      = in_item.end_of_message;
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign long_ok = b[7] && (b[6:0] != 7'd0) && (b[6:0] <= 7'(LENGTH_BYTES));

  // Header decode: tag, length and value countdown
  always_comb begin
    tag_nxt  = tag_r;
    cons_nxt = cons_r;
    acc_nxt  = acc_r;
    lb_nxt   = lb_left_r;
    lb_dec   = lb_left_r;
    vbl_dec  = vbl_r;
    hc       = 1'b0;
    bad      = 1'b0;
    vlen     = '0;
    case (phase_r)
      btlv_pkg::PH_TAG1: begin
        tag_nxt  = {8'h00, b};
        cons_nxt = (b & btlv_pkg::CONSTRUCTED_BIT) != 8'h00;
      end
      btlv_pkg::PH_TAG2: begin
        tag_nxt = {tag_r[7:0], b};
      end
      btlv_pkg::PH_LEN: begin
        if (!b[7]) begin
          hc   = 1'b1;
          vlen = LW'(b);
        end else if (long_ok) begin
          lb_nxt  = LB_W'(b[6:0]);
          acc_nxt = '0;
        end else begin
          hc  = 1'b1;
          bad = 1'b1;
        end
      end
      btlv_pkg::PH_LEXT: begin
        acc_nxt = {acc_r[LW-9:0], b};
        lb_dec  = (lb_left_r != '0) ? lb_left_r - 1'b1 : lb_left_r;
        lb_nxt  = lb_dec;
        if (lb_dec == '0) begin
          hc   = 1'b1;
          vlen = acc_nxt;
        end
      end
      default: begin
        vbl_dec = (vbl_r != '0) ? vbl_r - 1'b1 : vbl_r;
      end
    endcase
  end

  // Innermost open level, after this byte's countdown
  assign top_v = open_v & ~(open_v >> 1);

  always_comb begin
    parent = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (top_v[i]) begin
        parent = parent | left_v[i];
      end
    end
  end

  assign has_parent = open_levels_r != '0;
  assign elem_ok    = hc && !bad;
  assign overrun    = elem_ok && has_parent && (vlen > parent);
  assign room       = overrun ? parent : vlen;
  assign room_ok    = (32'(open_levels_r) < 32'(depth_limit_r)) &&
                      (32'(open_levels_r) < 32'(MAX_LEVELS));
  assign push       = elem_ok && cons_nxt && room_ok;
  assign too_deep   = elem_ok && cons_nxt && !room_ok;
  assign prim_start = elem_ok && !cons_nxt && (vlen != '0);
  assign vbl_nxt    = prim_start ? vlen : vbl_dec;

  // Next phase
  always_comb begin
    case (phase_r)
      btlv_pkg::PH_TAG1: begin
        phase_nxt = ((b & btlv_pkg::TAG_MULTI_MASK) == btlv_pkg::TAG_MULTI_MASK) ?
                    btlv_pkg::PH_TAG2 : btlv_pkg::PH_LEN;
      end
      btlv_pkg::PH_TAG2: phase_nxt = btlv_pkg::PH_LEN;
      btlv_pkg::PH_LEN:  phase_nxt = btlv_pkg::PH_LEXT;
      btlv_pkg::PH_LEXT: phase_nxt = btlv_pkg::PH_LEXT;
      default: begin
        phase_nxt = (vbl_dec == '0) ? btlv_pkg::PH_TAG1 : btlv_pkg::PH_VAL;
      end
    endcase
    if (hc) begin
      phase_nxt = prim_start ? btlv_pkg::PH_VAL : btlv_pkg::PH_TAG1;
    end
  end

  // Level cell chain
  assign cell_ctl.step  = in_acc;
  assign cell_ctl.flush = eom;
  assign cell_ctl.push  = push;
  assign cell_ctl.room  = room;

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
    logic below_open;
    if (g == 0) begin : g_first
      assign below_open = 1'b1;
    end else begin : g_rest
      assign below_open = open_v[g-1];
    end
    btlv_level_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (cell_ctl),
      .below_open_i (below_open),
      .open_o       (open_v[g]),
      .left_o       (left_v[g]),
      .closed_o     (closed_v[g])
    );
  end

  always_comb begin
    closed_cnt = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      closed_cnt = closed_cnt + CNT_W'(closed_v[i]);
    end
  end

  assign open_nxt  = open_levels_r + CNT_W'(push) - closed_cnt;
  assign close_err = (closed_cnt != '0) && (phase_nxt != btlv_pkg::PH_TAG1);

  // Keep the first error of the message
  always_comb begin
    if (err_r != btlv_pkg::ERR_NONE) begin
      err_nxt = err_r;
    end else if (bad) begin
      err_nxt = btlv_pkg::ERR_LEN_FORM;
    end else if (overrun) begin
      err_nxt = btlv_pkg::ERR_OVERRUN;
    end else if (too_deep) begin
      err_nxt = btlv_pkg::ERR_TOO_DEEP;
    end else if (close_err) begin
      err_nxt = btlv_pkg::ERR_OVERRUN;
    end else begin
      err_nxt = btlv_pkg::ERR_NONE;
    end
  end

  always_comb begin
    out_item_nxt.byte_role       = 3'(phase_r);
    out_item_nxt.tag_number      = tag_nxt;
    out_item_nxt.tag_class       = (tag_nxt[15:8] != 8'h00) ? tag_nxt[15:14] : tag_nxt[7:6];
    out_item_nxt.is_constructed  = cons_nxt;
    out_item_nxt.nesting_depth   = 3'(open_levels_r);
    out_item_nxt.value_length    = hc ? vlen : '0;
    out_item_nxt.header_complete = hc;
    out_item_nxt.levels_closed   = 3'(closed_cnt);
    out_item_nxt.error_code      = err_nxt;
    out_item_nxt.last_result     = eom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= btlv_pkg::PH_TAG1;
      tag_r         <= '0;
      cons_r        <= 1'b0;
      acc_r         <= '0;
      lb_left_r     <= '0;
      vbl_r         <= '0;
      open_levels_r <= '0;
      err_r         <= btlv_pkg::ERR_NONE;
    end else if (in_acc) begin
      if (eom) begin
        // drop all message state after the final byte
        phase_r       <= btlv_pkg::PH_TAG1;
        tag_r         <= '0;
        cons_r        <= 1'b0;
        acc_r         <= '0;
        lb_left_r     <= '0;
        vbl_r         <= '0;
        open_levels_r <= '0;
        err_r         <= btlv_pkg::ERR_NONE;
      end else begin
        phase_r       <= phase_nxt;
        tag_r         <= tag_nxt;
        cons_r        <= cons_nxt;
        acc_r         <= acc_nxt;
        lb_left_r     <= lb_nxt;
        vbl_r         <= vbl_nxt;
        open_levels_r <= open_nxt;
        err_r         <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_limit_r <= btlv_pkg::DEPTH_LIMIT_RST;
    end else if (cfg_wr_en) begin
      depth_limit_r <= cfg_wr_data;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Open cells form a contiguous run from the outermost level
  a_open_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    ((open_v >> 1) & ~open_v) == '0)
    else $error("level cells not contiguous");

  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(open_v) == int'(open_levels_r))
    else $error("open level count disagrees with cells");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(open_levels_r) <= 32'(MAX_LEVELS))
    else $error("open levels beyond cell count");

  a_eom_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eom) |=> (phase_r == btlv_pkg::PH_TAG1 && open_levels_r == '0 &&
                         err_r == btlv_pkg::ERR_NONE))
    else $error("parser not idle after final byte");

  a_hc_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.header_complete) |->
      (out_item.byte_role == 3'(btlv_pkg::PH_LEN) ||
       out_item.byte_role == 3'(btlv_pkg::PH_LEXT)))
    else $error("header completed on a non-length byte");

endmodule

[rtl/btlv_level_cell.sv]
// ----------------------------------------------------------------------------
// btlv_level_cell
// One nesting level: open flag and remaining byte count of a template.
// ----------------------------------------------------------------------------
module btlv_level_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  btlv_pkg::btlv_cell_ctl_t ctl,
  input  logic                     below_open_i,
  output logic                     open_o,
  output logic [btlv_pkg::LEN_W-1:0] left_o,
  output logic                     closed_o
);

  logic                       open_r;
  logic                       open_nxt;
  logic [btlv_pkg::LEN_W-1:0] left_r;
  logic [btlv_pkg::LEN_W-1:0] left_nxt;
  logic [btlv_pkg::LEN_W-1:0] left_dec;
  logic                       take;
  logic                       open_aft;

  // count down every accepted byte while open
  assign left_dec = (open_r && (left_r != '0)) ? left_r - 1'b1 : left_r;

  // the first free cell, above an open one or at the chain's base, takes a new template
  assign take     = ctl.push && !open_r && below_open_i;
  assign open_aft = open_r || take;
  assign left_nxt = take ? ctl.room : left_dec;
  assign closed_o = open_aft && (left_nxt == '0);
  assign open_nxt = ctl.flush ? 1'b0 : (open_aft && !closed_o);

  assign open_o = open_r;
  assign left_o = left_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (ctl.step) begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      left_r <= left_nxt;
    end
  end

endmodule
